@@ design/bqse_pkg.sv @@
// Shared types and fixed-point widths for the bilinear quad shape evaluator.
// Used by every module of the block; has no dependencies.
package bqse_pkg;

	localparam int NODES    = 4;          // corner nodes / lanes
	localparam int ONE_Q14  = 16384;      // 1.0 in Q2.14
	localparam int CW       = 16;         // input coordinate width
	localparam int JW       = 26;         // Jacobian entry, Q.16
	localparam int FW       = 17;         // (1 +- xi) style factors, Q.14
	localparam int PW       = 43;         // J entry times factor
	localparam int SPW      = 34;         // shape product, Q.28
	localparam int NUMW     = PW + 1;     // signed numerator
	localparam int NW       = 41;         // numerator magnitude
	localparam int DETW     = 53;         // signed determinant, Q.32
	localparam int DW       = 51;         // determinant magnitude
	localparam int FRAC     = 16;         // numerator bits held back in the dividend
	localparam int QW       = 33;         // raw quotient bits (Q.17)
	localparam int DIV_LAT  = QW + 2;     // divider: entry, one stage per bit, output
	localparam int PIPE_DEPTH = 5 + DIV_LAT; // stages from accept to the result buffer

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [JW-1:0] jent_t;
	typedef logic signed [FW-1:0] fac_t;

	typedef struct packed {
		logic [NODES-1:0][14:0] shape;
		logic [NODES-1:0][31:0] dx;
		logic [NODES-1:0][31:0] dy;
		logic [31:0]            det;
		logic                   sing;
	} item_t;

endpackage

@@ design/bilinear_quad_shape_eval.sv @@
// Top level of the bilinear quad shape evaluator.
// Depends on bqse_pkg, bqse_front, bqse_lane, bqse_ser.
//
// Usage:
//  - Point channel (point_valid / point_stall): one transaction carries xi, eta
//    (Q2.14) and the four corner coordinates (Q8.8).
//  - Result channel (result_valid / result_stall): four transactions per point,
//    node_index 0..3 in order, last set on node 3. Each gives the shape value,
//    dN/dx, dN/dy (Q16.16, saturated), the determinant and the singular flag.
//  - Pipeline: 40 stages (5 setup stages and a 35-stage divider) carry a point
//    from accept to the result buffer, which loads it from the last stage.
//  - New points enter while earlier ones are in flight, paced by the single
//    result port (four node results per point). Up to 41 points are in flight.
//  - Four lanes, one per node, each with two pipelined dividers (one quotient
//    bit per stage) for dN/dx and dN/dy; the result buffer merges the lanes.
//  - When the result side stalls, the buffer holds its item, the whole pipeline
//    freezes once its last stage is occupied, and point_stall rises.
//  - Reset clears the valid bits and empties the result buffer; no clearing pass.
module bilinear_quad_shape_eval import bqse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        point_valid,
	output logic        point_stall,
	input  logic [15:0] xi,
	input  logic [15:0] eta,
	input  logic [15:0] node0_x,
	input  logic [15:0] node0_y,
	input  logic [15:0] node1_x,
	input  logic [15:0] node1_y,
	input  logic [15:0] node2_x,
	input  logic [15:0] node2_y,
	input  logic [15:0] node3_x,
	input  logic [15:0] node3_y,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  node_index,
	output logic [14:0] shape_value,
	output logic [31:0] deriv_x,
	output logic [31:0] deriv_y,
	output logic [31:0] jacobian_det,
	output logic        singular,
	output logic        last
);

	logic                  en;
	logic                  free;
	logic [PIPE_DEPTH-1:0] vld_q;     // bit 0 is stage 1
	coord_t                nx [NODES];
	coord_t                ny [NODES];
	jent_t                 j00_s2, j01_s2, j10_s2, j11_s2;
	fac_t                  fxi_s2 [NODES];
	fac_t                  fet_s2 [NODES];
	fac_t                  dxi_s2 [NODES];
	fac_t                  deta_s2 [NODES];
	logic [31:0]           det16_s4;
	logic                  sing_s4;
	logic                  det_neg_s4;
	logic [DW-1:0]         dabs_s5;
	logic [31:0]           det_dly_q [DIV_LAT+1];
	logic                  sing_dly_q [DIV_LAT+1];
	item_t                 item;

	// pipeline moves unless its last stage holds an item the buffer cannot take
	assign en          = !vld_q[PIPE_DEPTH-1] || free;
	assign point_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], point_valid};
		end
	end

	assign nx = '{coord_t'(node0_x), coord_t'(node1_x), coord_t'(node2_x), coord_t'(node3_x)};
	assign ny = '{coord_t'(node0_y), coord_t'(node1_y), coord_t'(node2_y), coord_t'(node3_y)};

	bqse_front u_front (
		.clk(clk), .en(en), .xi(coord_t'(xi)), .eta(coord_t'(eta)), .nx(nx), .ny(ny),
		.j00_s2(j00_s2), .j01_s2(j01_s2), .j10_s2(j10_s2), .j11_s2(j11_s2),
		.fxi_s2(fxi_s2), .fet_s2(fet_s2), .dxi_s2(dxi_s2), .deta_s2(deta_s2),
		.det16_s4(det16_s4), .sing_s4(sing_s4), .det_neg_s4(det_neg_s4),
		.dabs_s5(dabs_s5)
	);

	for (genvar k = 0; k < NODES; k++) begin : g_lane
		logic signed [31:0] dx, dy;
		bqse_lane u_lane (
			.clk(clk), .en(en),
			.j00(j00_s2), .j01(j01_s2), .j10(j10_s2), .j11(j11_s2),
			.fxi(fxi_s2[k]), .fet(fet_s2[k]), .dxi(dxi_s2[k]), .deta(deta_s2[k]),
			.det_neg_s4(det_neg_s4), .dabs_s5(dabs_s5),
			.shape(item.shape[k]), .dx(dx), .dy(dy)
		);
		assign item.dx[k] = dx;
		assign item.dy[k] = dy;
	end

	// determinant and singular flag wait for the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			det_dly_q[0]  <= det16_s4;
			sing_dly_q[0] <= sing_s4;
			for (int i = 1; i <= DIV_LAT; i++) begin
				det_dly_q[i]  <= det_dly_q[i-1];
				sing_dly_q[i] <= sing_dly_q[i-1];
			end
		end
	end

	assign item.det  = det_dly_q[DIV_LAT];
	assign item.sing = sing_dly_q[DIV_LAT];

	bqse_ser u_ser (
		.clk(clk), .arst_n(arst_n),
		.item_valid(vld_q[PIPE_DEPTH-1]), .item(item), .free(free),
		.result_valid(result_valid), .result_stall(result_stall),
		.node_index(node_index), .shape_value(shape_value),
		.deriv_x(deriv_x), .deriv_y(deriv_y), .jacobian_det(jacobian_det),
		.singular(singular), .last(last)
	);

endmodule

@@ design/bqse_div.sv @@
// Pipelined restoring divider: rounded, signed, saturated Q16.16 quotient.
// One quotient bit per stage; depends on bqse_pkg.
module bqse_div import bqse_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	input  logic                neg,
	output logic signed [31:0]  quo
);

	logic [DW-1:0] rem_q [QW+1];
	logic [QW-1:0] low_q [QW+1];
	logic [DW-1:0] den_q [QW+1];
	logic [QW:0]   neg_q;
	logic [QW:0]   ovf_q;
	logic [31:0]   quo_q;
	logic [QW:0]   qr;

	// entry: top of dividend as partial remainder; quotient overflow if it is not below den
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= DW'(num[NW-1:FRAC]);
			low_q[0] <= {num[FRAC-1:0], (QW-FRAC)'(0)};
			den_q[0] <= den;
			neg_q[0] <= neg;
			ovf_q[0] <= DW'(num[NW-1:FRAC]) >= den;
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_step
		logic [DW:0] t;
		logic        ge;
		assign t  = {rem_q[i-1], low_q[i-1][QW-1]};
		assign ge = t >= {1'b0, den_q[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? DW'(t - {1'b0, den_q[i-1]}) : DW'(t);
				low_q[i] <= {low_q[i-1][QW-2:0], ge};
				den_q[i] <= den_q[i-1];
				neg_q[i] <= neg_q[i-1];
				ovf_q[i] <= ovf_q[i-1];
			end
		end
	end

	// half-up on the extra fraction bit
	assign qr = ({1'b0, low_q[QW]} + (QW+1)'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_q[QW]) begin
				quo_q <= neg_q[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else if (neg_q[QW]) begin
				quo_q <= (qr > (QW+1)'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'((QW+1)'(0) - qr);
			end else begin
				quo_q <= (qr > (QW+1)'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : 32'(qr);
			end
		end
	end

	assign quo = quo_q;

endmodule

@@ design/bqse_front.sv @@
// Shared front end: Jacobian entries, per-node factors and the determinant.
// Depends on bqse_pkg.
module bqse_front import bqse_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  coord_t            xi,
	input  coord_t            eta,
	input  coord_t            nx [NODES],
	input  coord_t            ny [NODES],
	output jent_t             j00_s2,
	output jent_t             j01_s2,
	output jent_t             j10_s2,
	output jent_t             j11_s2,
	output fac_t              fxi_s2 [NODES],
	output fac_t              fet_s2 [NODES],
	output fac_t              dxi_s2 [NODES],
	output fac_t              deta_s2 [NODES],
	output logic [31:0]       det16_s4,
	output logic              sing_s4,
	output logic              det_neg_s4,
	output logic [DW-1:0]     dabs_s5
);

	coord_t                 xi_s1, eta_s1;
	coord_t                 nx_s1 [NODES];
	coord_t                 ny_s1 [NODES];
	logic signed [17:0]     ex [NODES];
	logic signed [17:0]     ey [NODES];
	logic signed [17:0]     xa, xb, xc, ya, yb, yc;
	fac_t                   mx, px, me, pe;
	logic signed [51:0]     p0_s3, p1_s3;
	logic signed [DETW-1:0] det_c, det_r, det32_s4;

	// J entry at Q.24 exact, rounded half up to Q.16
	function automatic jent_t jround(input logic signed [17:0] a, input logic signed [17:0] c,
			input coord_t t);
		logic signed [34:0] s;
		s = (35'(a) <<< 14) + 35'(c) * 35'(t) + 35'sd128;
		return s[33:8];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			xi_s1  <= xi;
			eta_s1 <= eta;
			nx_s1  <= nx;
			ny_s1  <= ny;
		end
	end

	always_comb begin
		for (int k = 0; k < NODES; k++) begin
			ex[k] = 18'(nx_s1[k]);
			ey[k] = 18'(ny_s1[k]);
		end
		xa = ex[1] + ex[2] - ex[0] - ex[3];
		xb = ex[2] + ex[3] - ex[0] - ex[1];
		xc = ex[0] + ex[2] - ex[1] - ex[3];
		ya = ey[1] + ey[2] - ey[0] - ey[3];
		yb = ey[2] + ey[3] - ey[0] - ey[1];
		yc = ey[0] + ey[2] - ey[1] - ey[3];
		mx = FW'(ONE_Q14) - FW'(xi_s1);
		px = FW'(ONE_Q14) + FW'(xi_s1);
		me = FW'(ONE_Q14) - FW'(eta_s1);
		pe = FW'(ONE_Q14) + FW'(eta_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			j00_s2 <= jround(xa, xc, eta_s1);
			j10_s2 <= jround(xb, xc, xi_s1);
			j01_s2 <= jround(ya, yc, eta_s1);
			j11_s2 <= jround(yb, yc, xi_s1);
			fxi_s2  <= '{mx, px, px, mx};
			fet_s2  <= '{me, me, pe, pe};
			dxi_s2  <= '{-me, me, pe, -pe};
			deta_s2 <= '{-mx, -px, px, mx};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s3 <= 52'(j00_s2) * 52'(j11_s2);
			p1_s3 <= 52'(j01_s2) * 52'(j10_s2);
		end
	end

	assign det_c = DETW'(p0_s3) - DETW'(p1_s3);
	assign det_r = (det_c + DETW'(32768)) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			det32_s4   <= det_c;
			det_neg_s4 <= det_c[DETW-1];
			sing_s4    <= (det_r == '0);
			if (det_r > DETW'(64'sd2147483647)) begin
				det16_s4 <= 32'h7FFF_FFFF;
			end else if (det_r < -DETW'(64'sd2147483648)) begin
				det16_s4 <= 32'h8000_0000;
			end else begin
				det16_s4 <= det_r[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dabs_s5 <= det32_s4[DETW-1] ? DW'(-det32_s4) : DW'(det32_s4);
		end
	end

endmodule

@@ design/bqse_lane.sv @@
// One node lane: shape value, derivative numerators and two dividers.
// Depends on bqse_pkg and bqse_div.
module bqse_lane import bqse_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  jent_t              j00,
	input  jent_t              j01,
	input  jent_t              j10,
	input  jent_t              j11,
	input  fac_t               fxi,
	input  fac_t               fet,
	input  fac_t               dxi,
	input  fac_t               deta,
	input  logic               det_neg_s4,
	input  logic [DW-1:0]      dabs_s5,
	output logic [14:0]        shape,
	output logic signed [31:0] dx,
	output logic signed [31:0] dy
);

	logic signed [PW-1:0]   a_s3, b_s3, c_s3, d_s3;
	logic signed [SPW-1:0]  sp_s3, sr;
	logic signed [NUMW-1:0] numx_s4, numy_s4;
	logic [14:0]            shape_s4;
	logic [NW-1:0]          nx_s5, ny_s5;
	logic                   sx_s5, sy_s5;
	logic [14:0]            shape_dly_q [DIV_LAT+1];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3  <= PW'(j11) * PW'(dxi);
			b_s3  <= PW'(j01) * PW'(deta);
			c_s3  <= PW'(j00) * PW'(deta);
			d_s3  <= PW'(j10) * PW'(dxi);
			sp_s3 <= SPW'(fxi) * SPW'(fet);
		end
	end

	assign sr = (sp_s3 + SPW'(32768)) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s4 <= NUMW'(a_s3) - NUMW'(b_s3);
			numy_s4 <= NUMW'(c_s3) - NUMW'(d_s3);
			if (sr < 0) begin
				shape_s4 <= '0;
			end else if (sr > SPW'(ONE_Q14)) begin
				shape_s4 <= 15'(ONE_Q14);
			end else begin
				shape_s4 <= sr[14:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5 <= numx_s4[NUMW-1] ? NW'(-numx_s4) : NW'(numx_s4);
			ny_s5 <= numy_s4[NUMW-1] ? NW'(-numy_s4) : NW'(numy_s4);
			sx_s5 <= numx_s4[NUMW-1] ^ det_neg_s4;
			sy_s5 <= numy_s4[NUMW-1] ^ det_neg_s4;
		end
	end

	bqse_div u_div_x (.clk(clk), .en(en), .num(nx_s5), .den(dabs_s5), .neg(sx_s5), .quo(dx));
	bqse_div u_div_y (.clk(clk), .en(en), .num(ny_s5), .den(dabs_s5), .neg(sy_s5), .quo(dy));

	// shape rides alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			shape_dly_q[0] <= shape_s4;
			for (int i = 1; i <= DIV_LAT; i++) begin
				shape_dly_q[i] <= shape_dly_q[i-1];
			end
		end
	end

	assign shape = shape_dly_q[DIV_LAT];

endmodule

@@ design/bqse_ser.sv @@
// Result buffer: holds one finished item and sends its four node results in order.
// Depends on bqse_pkg.
module bqse_ser import bqse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  item_t       item,
	output logic        free,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  node_index,
	output logic [14:0] shape_value,
	output logic [31:0] deriv_x,
	output logic [31:0] deriv_y,
	output logic [31:0] jacobian_det,
	output logic        singular,
	output logic        last
);

	item_t      item_q;
	logic       full_q;
	logic [1:0] cnt_q;
	logic       done;
	logic       load;

	assign done = full_q && !result_stall && (cnt_q == 2'(NODES-1));
	assign free = !full_q || done;
	assign load = item_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			full_q <= 1'b0;
		end else if (full_q && !result_stall) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

	assign result_valid = full_q;
	assign node_index   = cnt_q;
	assign shape_value  = item_q.shape[cnt_q];
	assign deriv_x      = item_q.sing ? 32'd0 : item_q.dx[cnt_q];
	assign deriv_y      = item_q.sing ? 32'd0 : item_q.dy[cnt_q];
	assign jacobian_det = item_q.det;
	assign singular     = item_q.sing;
	assign last         = (cnt_q == 2'(NODES-1));

endmodule

@@ design/bqse_checker.sv @@
// Port-level checks for the bilinear quad shape evaluator, bound to the top level.
// Depends on bqse_pkg; sees only the top-level ports.
module bqse_checker import bqse_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  node_index,
	input logic [14:0] shape_value,
	input logic [31:0] deriv_x,
	input logic [31:0] deriv_y,
	input logic [31:0] jacobian_det,
	input logic        singular,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(node_index)
			&& $stable(deriv_x) && $stable(deriv_y) && $stable(shape_value)
			&& $stable(jacobian_det))
		else $error("stalled result transaction changed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last |=>
			result_valid && (node_index == $past(node_index) + 2'd1))
		else $error("node results out of order");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == (node_index == 2'(NODES-1))))
		else $error("last flag not on node 3");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && singular |-> (deriv_x == '0) && (deriv_y == '0))
		else $error("derivatives not zero on singular element");

	a_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (shape_value <= 15'(ONE_Q14)))
		else $error("shape value above one");

endmodule

bind bilinear_quad_shape_eval bqse_checker u_bqse_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench for bilinear_quad_shape_eval.
// Depends on bqse_pkg and the block; a built-in predictor checks all four node
// results of every point against the fixed-point rules of the block.
module tb_top import bqse_pkg::*;;

	// One point transaction: reference point plus four corners, raw 16-bit words.
	typedef struct packed {
		logic [15:0]      xi;
		logic [15:0]      eta;
		logic [3:0][15:0] nx;
		logic [3:0][15:0] ny;
	} point_t;

	// One node result as the block should emit it.
	typedef struct packed {
		logic [1:0]  idx;
		logic [14:0] shape;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] det;
		logic        sing;
		logic        last;
	} node_res_t;

	localparam int LIMIT_CYCLES = 300000;
	localparam int HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        point_valid = 1'b0;
	logic        point_stall;
	logic [15:0] xi = '0, eta = '0;
	logic [15:0] node0_x = '0, node0_y = '0, node1_x = '0, node1_y = '0;
	logic [15:0] node2_x = '0, node2_y = '0, node3_x = '0, node3_y = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  node_index;
	logic [14:0] shape_value;
	logic [31:0] deriv_x, deriv_y, jacobian_det;
	logic        singular, last;

	point_t    point_q[$];       // points waiting to be offered
	node_res_t node_expect_q[$]; // node results predicted, not yet seen
	int        point_total = 0;
	int        points_sent = 0;
	int        mismatches = 0;
	int        cycles = 0;
	int        phase;            // 0 none, 1 sender idles, 2 receiver stalls, 3 both
	int        hold_cnt = 0;
	bit        hold_done = 1'b0;
	bit        point_taken = 1'b0;

	bilinear_quad_shape_eval i_dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall),
		.xi(xi), .eta(eta),
		.node0_x(node0_x), .node0_y(node0_y), .node1_x(node1_x), .node1_y(node1_y),
		.node2_x(node2_x), .node2_y(node2_y), .node3_x(node3_x), .node3_y(node3_y),
		.result_valid(result_valid), .result_stall(result_stall),
		.node_index(node_index), .shape_value(shape_value),
		.deriv_x(deriv_x), .deriv_y(deriv_y), .jacobian_det(jacobian_det),
		.singular(singular), .last(last)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// Shift right with round half up (floor of v + half).
	function automatic longint round_shr(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// num/den at Q16.16, nearest with ties away from zero, saturated.
	function automatic longint div_q16(input longint num, input longint den);
		bit              neg;
		longint unsigned n, d, q;
		longint          r;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = ((n << 17) + d) / (d << 1);
		r = (q > 64'h3FFF_FFFF_FFFF_FFFF) ? 64'sh3FFF_FFFF_FFFF_FFFF : longint'(q);
		return sat32(neg ? -r : r);
	endfunction

	// Works out the four node results of one point and queues them.
	function automatic void predict_nodes(input point_t p);
		longint    s_xi, s_eta, x[4], y[4];
		longint    xa, xb, xc, ya, yb, yc;
		longint    j00, j10, j01, j11, det32, det16;
		longint    mx, px, me, pe, fxi[4], fet[4], dxi[4], deta[4];
		longint    n, dx, dy;
		bit        sing;
		node_res_t r;
		s_xi  = longint'($signed(p.xi));
		s_eta = longint'($signed(p.eta));
		for (int k = 0; k < 4; k++) begin
			x[k] = longint'($signed(p.nx[k]));
			y[k] = longint'($signed(p.ny[k]));
		end
		xa = -x[0] + x[1] + x[2] - x[3];
		xb = -x[0] - x[1] + x[2] + x[3];
		xc =  x[0] - x[1] + x[2] - x[3];
		ya = -y[0] + y[1] + y[2] - y[3];
		yb = -y[0] - y[1] + y[2] + y[3];
		yc =  y[0] - y[1] + y[2] - y[3];
		// Jacobian exact at Q.24, rounded to Q.16
		j00 = round_shr(xa * ONE_Q14 + xc * s_eta, 8);
		j10 = round_shr(xb * ONE_Q14 + xc * s_xi, 8);
		j01 = round_shr(ya * ONE_Q14 + yc * s_eta, 8);
		j11 = round_shr(yb * ONE_Q14 + yc * s_xi, 8);
		det32 = j00 * j11 - j01 * j10;
		det16 = round_shr(det32, 16);
		sing = (det16 == 0);
		mx = ONE_Q14 - s_xi;  px = ONE_Q14 + s_xi;
		me = ONE_Q14 - s_eta; pe = ONE_Q14 + s_eta;
		fxi  = '{mx, px, px, mx};
		fet  = '{me, me, pe, pe};
		dxi  = '{-me, me, pe, -pe};
		deta = '{-mx, -px, px, mx};
		for (int k = 0; k < 4; k++) begin
			n = round_shr(fxi[k] * fet[k], 16);
			if (n < 0) n = 0;
			if (n > ONE_Q14) n = ONE_Q14;
			dx = 0;
			dy = 0;
			if (!sing) begin
				dx = div_q16(j11 * dxi[k] - j01 * deta[k], det32);
				dy = div_q16(j00 * deta[k] - j10 * dxi[k], det32);
			end
			r.idx   = 2'(k);
			r.shape = 15'(n);
			r.dx    = 32'(dx);
			r.dy    = 32'(dy);
			r.det   = 32'(sat32(det16));
			r.sing  = sing;
			r.last  = (k == 3);
			node_expect_q.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic [15:0] clip16(input int v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return 16'(v);
	endfunction

	// Counterclockwise corners around (cx, cy), half size r, jitter up to j.
	function automatic point_t make_quad(input int cx, input int cy, input int r, input int j);
		point_t p;
		int     sx[4] = '{-1, 1, 1, -1};
		int     sy[4] = '{-1, -1, 1, 1};
		for (int k = 0; k < 4; k++) begin
			p.nx[k] = clip16(cx + sx[k] * r + $urandom_range(0, 2 * j) - j);
			p.ny[k] = clip16(cy + sy[k] * r + $urandom_range(0, 2 * j) - j);
		end
		p.xi  = 16'($urandom_range(0, 32768) - 16384);
		p.eta = 16'($urandom_range(0, 32768) - 16384);
		return p;
	endfunction

	function automatic point_t with_point(input point_t p, input int a, input int b);
		p.xi  = 16'(a);
		p.eta = 16'(b);
		return p;
	endfunction

	initial begin
		point_t p, unit_sq;
		int     sel, r;
		// Directed part. Square with corners at +-1.0, 1.0 in Q8.8 = 256.
		unit_sq = make_quad(0, 0, 256, 0);
		point_q.push_back(with_point(unit_sq, 0, 0));
		point_q.push_back(with_point(unit_sq, -16384, -16384));
		point_q.push_back(with_point(unit_sq, 16384, -16384));
		point_q.push_back(with_point(unit_sq, 16384, 16384));
		point_q.push_back(with_point(unit_sq, -16384, 16384));
		point_q.push_back(with_point(unit_sq, 8192, -4096));
		// points beyond the element, shape clamp
		point_q.push_back(with_point(unit_sq, 32767, -32768));
		point_q.push_back(with_point(unit_sq, -32768, 32767));
		// all corners equal: singular
		p = '0;
		point_q.push_back(with_point(p, 1234, -777));
		// collinear corners: singular
		for (int k = 0; k < 4; k++) begin
			p.nx[k] = 16'(k * 100);
			p.ny[k] = 16'(k * 100);
		end
		point_q.push_back(with_point(p, 0, 0));
		// one-lsb element, determinant of one lsb, not singular
		point_q.push_back(with_point(make_quad(50, -50, 1, 0), 3000, 3000));
		// tiny element that is not singular, large derivatives
		point_q.push_back(with_point(make_quad(0, 0, 2, 0), 0, 0));
		point_q.push_back(with_point(make_quad(0, 0, 3, 1), -16384, 16384));
		// corners reordered into the same square: counterclockwise, positive determinant
		p = unit_sq;
		p.nx = {unit_sq.nx[1], unit_sq.nx[2], unit_sq.nx[3], unit_sq.nx[0]};
		p.ny = {unit_sq.ny[3], unit_sq.ny[2], unit_sq.ny[1], unit_sq.ny[0]};
		p.nx = {unit_sq.nx[0], unit_sq.nx[1], unit_sq.nx[2], unit_sq.nx[3]};
		p.ny = {unit_sq.ny[2], unit_sq.ny[3], unit_sq.ny[0], unit_sq.ny[1]};
		point_q.push_back(with_point(p, 0, 0));
		// coordinate extremes, determinant large but within the 32-bit range
		p.nx = {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
		p.ny = {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000};
		point_q.push_back(with_point(p, 0, 0));
		point_q.push_back(with_point(p, 16384, -16384));
		p.nx = {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
		point_q.push_back(with_point(p, -16384, 16384));
		p.nx = {16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555};
		p.ny = {16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF};
		point_q.push_back(with_point(p, 16'hC000, 16'h4000));
		// skewed element, nonzero cross term
		point_q.push_back(with_point(make_quad(-3000, 2000, 800, 400), 5000, -7000));

		// Random part: mostly well-formed elements of many sizes.
		for (int i = 0; i < 380; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				r = $urandom_range(64, 4000);
				p = make_quad($urandom_range(0, 24000) - 12000,
					$urandom_range(0, 24000) - 12000, r, r / 2);
			end else if (sel < 72) begin
				r = $urandom_range(1, 6);
				p = make_quad($urandom_range(0, 65535) - 32768,
					$urandom_range(0, 65535) - 32768, r, r);
			end else if (sel < 80) begin
				p = make_quad(0, 0, $urandom_range(8000, 16383), 3000);
			end else if (sel < 92) begin
				// arbitrary corners, often twisted or inverted
				p = make_quad(0, 0, 0, 0);
				for (int k = 0; k < 4; k++) begin
					p.nx[k] = 16'($urandom);
					p.ny[k] = 16'($urandom);
				end
			end else begin
				// degenerate: corners on one line
				p = make_quad(0, 0, 0, 0);
				r = $urandom_range(0, 2000);
				for (int k = 0; k < 4; k++) begin
					p.nx[k] = clip16(k * r - 3000);
					p.ny[k] = clip16(2 * k * r + 17);
				end
			end
			sel = $urandom_range(0, 19);
			if (sel == 0) p.xi = 16'($urandom);
			if (sel == 1) p.eta = 16'($urandom);
			if (sel == 2) p = with_point(p, 16384, -16384);
			if (sel == 3) p = with_point(p, -16384, 16384);
			point_q.push_back(p);
		end
		point_total = point_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		wait (point_q.size() == 0 && !point_valid);
		wait (node_expect_q.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// Phase follows the share of points already handed over.
	always_comb phase = (point_total == 0) ? 0 : (points_sent * 4) / point_total;

	// Sender: holds the payload while stalled; may idle between transactions.
	always @(negedge clk) begin
		if (arst_n && (!point_valid || point_taken)) begin
			if (point_q.size() != 0 && !((phase == 1 || phase == 3) &&
				$urandom_range(0, 99) < ((phase == 1) ? 56 : 23))) begin
				point_t p;
				p = point_q.pop_front();
				xi <= p.xi;
				eta <= p.eta;
				{node3_x, node2_x, node1_x, node0_x} <= p.nx;
				{node3_y, node2_y, node1_y, node0_y} <= p.ny;
				point_valid <= 1'b1;
				points_sent <= points_sent + 1;
			end else begin
				point_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off once, early in the stalling phase, so the
	// pipeline fills and pushes back on the point channel.
	always @(negedge clk) begin
		if (!hold_done && phase == 2) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(negedge clk) begin
		result_stall <= (hold_cnt > 0) ||
			((phase == 2 || phase == 3) && $urandom_range(0, 99) < (phase == 2 ? 56 : 23));
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		point_t    p;
		node_res_t got, want;
		point_taken <= point_valid && !point_stall;
		if (arst_n && point_valid && !point_stall) begin
			p.xi  = xi;
			p.eta = eta;
			p.nx  = {node3_x, node2_x, node1_x, node0_x};
			p.ny  = {node3_y, node2_y, node1_y, node0_y};
			predict_nodes(p);
		end
		if (arst_n && result_valid && !result_stall) begin
			got = '{node_index, shape_value, deriv_x, deriv_y, jacobian_det, singular, last};
			if (node_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: node %0d", node_index);
			end else begin
				want = node_expect_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp node %0d N %0d dx %h dy %h det %h s %b l %b",
							want.idx, want.shape, want.dx, want.dy, want.det, want.sing,
							want.last);
						$display("          got node %0d N %0d dx %h dy %h det %h s %b l %b",
							got.idx, got.shape, got.dx, got.dy, got.det, got.sing,
							got.last);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

endmodule

@@ sim.f @@
design/bqse_pkg.sv
design/bqse_div.sv
design/bqse_front.sv
design/bqse_lane.sv
design/bqse_ser.sv
design/bilinear_quad_shape_eval.sv
design/bqse_checker.sv
bench/tb_top.sv
